// ----- rtl/mmcc_pkg.sv -----
// Shared types, codes, reset values and helpers of the motor CAN codec.
`default_nettype none
package mmcc_pkg;

   // Actions carried in an input word.
   localparam logic [1:0] ACT_FEEDBACK = 2'd0;
   localparam logic [1:0] ACT_TARGETS  = 2'd1;
   localparam logic [1:0] ACT_COMMAND  = 2'd2;
   localparam logic [1:0] ACT_ADMIN    = 2'd3;

   // Admin kinds and frame tails.
   localparam logic [1:0] ADMIN_ENTER = 2'd0;
   localparam logic [1:0] ADMIN_BAD   = 2'd3;
   localparam logic [7:0] TAIL_ENTER  = 8'hFC;
   localparam logic [55:0] ADMIN_HEAD = 56'hFF_FFFF_FFFF_FFFF;

   // Result kinds.
   localparam logic KIND_FRAME    = 1'b0;
   localparam logic KIND_FEEDBACK = 1'b1;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_FEEDBACK_ID = 3'd0;
   localparam logic [2:0] REG_COMMAND_ID  = 3'd1;
   localparam logic [2:0] REG_ANGLE_LIM   = 3'd2;
   localparam logic [2:0] REG_SPEED_LIM   = 3'd3;
   localparam logic [2:0] REG_TORQUE_LIM  = 3'd4;
   localparam logic [2:0] REG_STIFF_LIM   = 3'd5;
   localparam logic [2:0] REG_DAMP_LIM    = 3'd6;
   localparam logic [2:0] REG_ENTER_SEND  = 3'd7;

   // Register reset values.
   localparam logic [10:0] RST_FEEDBACK_ID = 11'd0;
   localparam logic [10:0] RST_COMMAND_ID  = 11'd1;
   localparam logic [30:0] RST_ANGLE_LIM   = 31'd823550;
   localparam logic [30:0] RST_SPEED_LIM   = 31'd3276800;
   localparam logic [30:0] RST_TORQUE_LIM  = 31'd1179648;
   localparam logic [30:0] RST_STIFF_LIM   = 31'd32768000;
   localparam logic [30:0] RST_DAMP_LIM    = 31'd327680;

   // Full scale of the 16-bit and 12-bit packed fields.
   localparam logic [15:0] FULL16 = 16'hFFFF;
   localparam logic [15:0] FULL12 = 16'h0FFF;

   // Clamp a signed value to -lim..lim.
   function automatic logic signed [31:0] clamp_sym(input logic signed [31:0] x,
                                                   input logic [30:0] lim);
      logic signed [32:0] xs;
      logic signed [32:0] hi;
      logic signed [32:0] lo;
      xs = $signed({x[31], x});
      hi = $signed({2'b00, lim});
      lo = -hi;
      if (xs > hi) begin
         return hi[31:0];
      end else if (xs < lo) begin
         return lo[31:0];
      end
      return x;
   endfunction

   // Clamp a signed gain to 0..lim.
   function automatic logic [30:0] clamp_gain(input logic signed [31:0] g,
                                              input logic [30:0] lim);
      if (g[31]) begin
         return 31'd0;
      end else if (g[30:0] > lim) begin
         return lim;
      end
      return g[30:0];
   endfunction

endpackage
`default_nettype wire

// ----- rtl/mmcc_req_if.sv -----
// Input channel of the motor CAN codec.
`default_nettype none
interface mmcc_req_if import mmcc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [10:0]        rx_frame_id;
   logic [63:0]        rx_payload;
   logic signed [31:0] want_angle;
   logic signed [31:0] want_speed;
   logic signed [31:0] want_torque;
   logic signed [31:0] stiffness;
   logic signed [31:0] damping;
   logic [1:0]         admin_kind;

   modport source (output valid, action, rx_frame_id, rx_payload, want_angle, want_speed,
                   want_torque, stiffness, damping, admin_kind, input ready);
   modport sink (input valid, action, rx_frame_id, rx_payload, want_angle, want_speed,
                 want_torque, stiffness, damping, admin_kind, output ready);
endinterface
`default_nettype wire

// ----- rtl/mmcc_rsp_if.sv -----
// Result channel of the motor CAN codec.
`default_nettype none
interface mmcc_rsp_if import mmcc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [10:0]        tx_id;
   logic [63:0]        tx_payload;
   logic signed [31:0] meas_angle;
   logic signed [31:0] meas_speed;
   logic signed [31:0] meas_torque;
   logic signed [47:0] turns_angle;
   logic               last;

   modport source (output valid, kind, tx_id, tx_payload, meas_angle, meas_speed,
                   meas_torque, turns_angle, last, input ready);
   modport sink (input valid, kind, tx_id, tx_payload, meas_angle, meas_speed,
                 meas_torque, turns_angle, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/mit_motor_can_codec_unit.sv -----
// Top level of the motor CAN codec: sequencer, shared multiply-divide unit and registers.
//
//   channel  | direction | handshake        | content
//   req_chan | in        | valid / ready    | action word with frame and targets
//   rsp_chan | out       | valid / ready    | outgoing frame or decoded feedback
//   csr_*    | in        | APB write / read | eight limit and id registers
//
// A feedback word scales three fields and a command word five: every scaled field passes
// the multiply state, a 48-bit restoring divide and the store state, and a feedback word
// then passes the wrap state. Targets and admin words do not use the divider.
// Reset is synchronous, sets the registers to their reset values and clears the tracked angle and the targets.
// The block takes no word while a word is in work; a finished word waits in the
// output register, and a new word is taken meanwhile up to its own result.
`default_nettype none
module mit_motor_can_codec_unit import mmcc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   mmcc_req_if.sink         req_chan,
   mmcc_rsp_if.source       rsp_chan,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_STORE = 3'd3;
   localparam logic [2:0] S_WRAP  = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;
   localparam logic [2:0] S_FIN2  = 3'd6;

   localparam logic [5:0] DIV_LAST = 6'd47;

   // Configuration registers.
   logic [10:0] feedback_id_ff;
   logic [10:0] command_id_ff;
   logic [30:0] angle_lim_ff;
   logic [30:0] speed_lim_ff;
   logic [30:0] torque_lim_ff;
   logic [30:0] stiff_lim_ff;
   logic [30:0] damp_lim_ff;
   logic        enter_send_ff;

   // Sequencer and datapath state.
   logic [2:0]         state_ff, state_in;
   logic [1:0]         act_ff;
   logic [2:0]         op_ff;
   logic [5:0]         cnt_ff;
   logic [32:0]        rem_ff;
   logic [47:0]        quo_ff;
   logic [31:0]        den_ff;
   logic               zero_ff;
   logic [39:0]        pl_ff;
   logic signed [31:0] stiff_ff;
   logic signed [31:0] damp_ff;
   logic [7:0]         tail_ff;
   logic [31:0]        res_ff [0:4];
   logic signed [32:0] delta_ff;

   // Tracked angle and stored targets.
   logic               seeded_ff;
   logic signed [31:0] prev_ff;
   logic signed [47:0] total_ff;
   logic signed [31:0] hold_angle_ff;
   logic signed [31:0] hold_speed_ff;
   logic signed [31:0] hold_torque_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic               kind_ff;
   logic [10:0]        tx_id_ff;
   logic [63:0]        tx_payload_ff;
   logic signed [31:0] meas_angle_ff;
   logic signed [31:0] meas_speed_ff;
   logic signed [31:0] meas_torque_ff;
   logic signed [47:0] turns_ff;
   logic               last_ff;

   logic        csr_wr;
   logic [2:0]  csr_idx;
   logic        req_take;
   logic        out_free;
   logic        out_load;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];
   assign req_take   = req_chan.valid & req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign out_free   = ~rsp_valid_ff | rsp_chan.ready;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         feedback_id_ff <= RST_FEEDBACK_ID;
         command_id_ff  <= RST_COMMAND_ID;
         angle_lim_ff   <= RST_ANGLE_LIM;
         speed_lim_ff   <= RST_SPEED_LIM;
         torque_lim_ff  <= RST_TORQUE_LIM;
         stiff_lim_ff   <= RST_STIFF_LIM;
         damp_lim_ff    <= RST_DAMP_LIM;
         enter_send_ff  <= 1'b0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_FEEDBACK_ID: feedback_id_ff <= csr_pwdata[10:0];
            REG_COMMAND_ID:  command_id_ff  <= csr_pwdata[10:0];
            REG_ANGLE_LIM:   angle_lim_ff   <= csr_pwdata[30:0];
            REG_SPEED_LIM:   speed_lim_ff   <= csr_pwdata[30:0];
            REG_TORQUE_LIM:  torque_lim_ff  <= csr_pwdata[30:0];
            REG_STIFF_LIM:   stiff_lim_ff   <= csr_pwdata[30:0];
            REG_DAMP_LIM:    damp_lim_ff    <= csr_pwdata[30:0];
            REG_ENTER_SEND:  enter_send_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      case (csr_idx)
         REG_FEEDBACK_ID: csr_prdata = {21'd0, feedback_id_ff};
         REG_COMMAND_ID:  csr_prdata = {21'd0, command_id_ff};
         REG_ANGLE_LIM:   csr_prdata = {1'b0, angle_lim_ff};
         REG_SPEED_LIM:   csr_prdata = {1'b0, speed_lim_ff};
         REG_TORQUE_LIM:  csr_prdata = {1'b0, torque_lim_ff};
         REG_STIFF_LIM:   csr_prdata = {1'b0, stiff_lim_ff};
         REG_DAMP_LIM:    csr_prdata = {1'b0, damp_lim_ff};
         REG_ENTER_SEND:  csr_prdata = {31'd0, enter_send_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   // Operand selection for the shared unit: product a * b, divided by den.
   logic [30:0]        op_lim;
   logic [31:0]        mul_a;
   logic [15:0]        mul_b;
   logic [31:0]        op_den;
   logic               op_zero;
   logic signed [31:0] sym_x;
   logic signed [31:0] sym_c;
   logic [32:0]        sym_off;
   logic [2:0]         op_last;

   always_comb begin
      op_lim  = angle_lim_ff;
      sym_x   = hold_angle_ff;
      mul_a   = 32'd0;
      mul_b   = FULL12;
      op_den  = {1'b0, angle_lim_ff};
      op_zero = 1'b0;
      op_last = (act_ff == ACT_FEEDBACK) ? 3'd2 : 3'd4;
      if (act_ff == ACT_FEEDBACK) begin
         case (op_ff)
            3'd0:    op_lim = angle_lim_ff;
            3'd1:    op_lim = speed_lim_ff;
            default: op_lim = torque_lim_ff;
         endcase
      end else begin
         case (op_ff)
            3'd0:    op_lim = angle_lim_ff;
            3'd1:    op_lim = speed_lim_ff;
            3'd2:    op_lim = stiff_lim_ff;
            3'd3:    op_lim = damp_lim_ff;
            default: op_lim = torque_lim_ff;
         endcase
         case (op_ff)
            3'd0:    sym_x = hold_angle_ff;
            3'd1:    sym_x = hold_speed_ff;
            default: sym_x = hold_torque_ff;
         endcase
      end
      sym_c   = clamp_sym(sym_x, op_lim);
      sym_off = 33'($signed({sym_c[31], sym_c}) + $signed({2'b00, op_lim}));
      if (act_ff == ACT_FEEDBACK) begin
         mul_a  = {op_lim, 1'b0};
         case (op_ff)
            3'd0:    mul_b = pl_ff[39:24];
            3'd1:    mul_b = {4'd0, pl_ff[23:12]};
            default: mul_b = {4'd0, pl_ff[11:0]};
         endcase
         op_den = {16'd0, (op_ff == 3'd0) ? FULL16 : FULL12};
      end else begin
         mul_b   = (op_ff == 3'd0) ? FULL16 : FULL12;
         op_zero = (op_lim == 31'd0);
         if (op_ff == 3'd2) begin
            mul_a  = {1'b0, clamp_gain(stiff_ff, op_lim)};
            op_den = {1'b0, op_lim};
         end else if (op_ff == 3'd3) begin
            mul_a  = {1'b0, clamp_gain(damp_ff, op_lim)};
            op_den = {1'b0, op_lim};
         end else begin
            mul_a  = sym_off[31:0];
            op_den = {op_lim, 1'b0};
         end
      end
   end

   // One restoring divide step.
   logic [32:0] div_sh;
   logic        div_ge;
   assign div_sh = {rem_ff[31:0], quo_ff[47]};
   assign div_ge = (div_sh >= {1'b0, den_ff});

   // Value stored for the current field once the quotient is complete.
   logic [31:0] store_val;
   logic [15:0] full_now;
   always_comb begin
      full_now = (op_ff == 3'd0) ? FULL16 : FULL12;
      if (act_ff == ACT_FEEDBACK) begin
         store_val = quo_ff[31:0] - {1'b0, op_lim};
      end else if (zero_ff) begin
         store_val = 32'd0;
      end else if (quo_ff > {32'd0, full_now}) begin
         store_val = {16'd0, full_now};
      end else begin
         store_val = {16'd0, quo_ff[15:0]};
      end
   end

   // Unwrapped step of the single-turn angle.
   logic signed [33:0] wrap_d;
   logic signed [33:0] wrap_l;
   logic signed [33:0] wrap_r;
   always_comb begin
      wrap_d = $signed({{2{res_ff[0][31]}}, res_ff[0]}) - $signed({{2{prev_ff[31]}}, prev_ff});
      wrap_l = $signed({3'b000, angle_lim_ff});
      if (wrap_d > wrap_l) begin
         wrap_r = wrap_d - (wrap_l <<< 1);
      end else if (wrap_d < -wrap_l) begin
         wrap_r = wrap_d + (wrap_l <<< 1);
      end else begin
         wrap_r = wrap_d;
      end
   end

   // Saturating multi-turn sum.
   logic signed [48:0] sum_t;
   logic signed [47:0] total_next;
   always_comb begin
      sum_t = $signed({total_ff[47], total_ff}) + 49'($signed(delta_ff));
      if (!seeded_ff) begin
         total_next = 48'($signed(res_ff[0]));
      end else if (sum_t[48] != sum_t[47]) begin
         total_next = sum_t[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
         total_next = sum_t[47:0];
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      out_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_chan.action)
                  ACT_FEEDBACK: begin
                     if (req_chan.rx_frame_id == feedback_id_ff) state_in = S_MUL;
                  end
                  ACT_COMMAND: state_in = S_MUL;
                  ACT_ADMIN: begin
                     if (req_chan.admin_kind != ADMIN_BAD) state_in = S_FIN;
                  end
                  default: ;
               endcase
            end
         end
         S_MUL: state_in = S_DIV;
         S_DIV: begin
            if (cnt_ff == DIV_LAST) state_in = S_STORE;
         end
         S_STORE: begin
            if (op_ff != op_last) begin
               state_in = S_MUL;
            end else begin
               state_in = (act_ff == ACT_FEEDBACK) ? S_WRAP : S_FIN;
            end
         end
         S_WRAP: state_in = S_FIN;
         S_FIN: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = (act_ff == ACT_COMMAND && enter_send_ff) ? S_FIN2 : S_IDLE;
            end
         end
         S_FIN2: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and tracked state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         seeded_ff      <= 1'b0;
         prev_ff        <= '0;
         total_ff       <= '0;
         hold_angle_ff  <= '0;
         hold_speed_ff  <= '0;
         hold_torque_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_take && req_chan.action == ACT_TARGETS) begin
            hold_angle_ff  <= clamp_sym(req_chan.want_angle, angle_lim_ff);
            hold_speed_ff  <= clamp_sym(req_chan.want_speed, speed_lim_ff);
            hold_torque_ff <= clamp_sym(req_chan.want_torque, torque_lim_ff);
         end
         if (state_ff == S_FIN && out_load && act_ff == ACT_FEEDBACK) begin
            seeded_ff <= 1'b1;
            prev_ff   <= res_ff[0];
            total_ff  <= total_next;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         act_ff   <= req_chan.action;
         op_ff    <= 3'd0;
         pl_ff    <= req_chan.rx_payload[55:16];
         stiff_ff <= req_chan.stiffness;
         damp_ff  <= req_chan.damping;
         tail_ff  <= TAIL_ENTER + {6'd0, req_chan.admin_kind};
      end
      case (state_ff)
         S_MUL: begin
            quo_ff  <= {16'd0, mul_a} * {32'd0, mul_b};
            rem_ff  <= '0;
            cnt_ff  <= '0;
            den_ff  <= op_den;
            zero_ff <= op_zero;
         end
         S_DIV: begin
            rem_ff <= div_ge ? (div_sh - {1'b0, den_ff}) : div_sh;
            quo_ff <= {quo_ff[46:0], div_ge};
            cnt_ff <= cnt_ff + 6'd1;
         end
         S_STORE: begin
            res_ff[op_ff] <= store_val;
            op_ff         <= op_ff + 3'd1;
         end
         S_WRAP: delta_ff <= wrap_r[32:0];
         default: ;
      endcase
   end

   // Output register load.
   always_ff @(posedge clock) begin
      if (out_load) begin
         kind_ff        <= KIND_FRAME;
         tx_id_ff       <= command_id_ff;
         tx_payload_ff  <= '0;
         meas_angle_ff  <= '0;
         meas_speed_ff  <= '0;
         meas_torque_ff <= '0;
         turns_ff       <= '0;
         last_ff        <= 1'b1;
         if (state_ff == S_FIN2) begin
            tx_payload_ff <= {ADMIN_HEAD, TAIL_ENTER};
         end else begin
            case (act_ff)
               ACT_FEEDBACK: begin
                  kind_ff        <= KIND_FEEDBACK;
                  tx_id_ff       <= '0;
                  meas_angle_ff  <= res_ff[0];
                  meas_speed_ff  <= res_ff[1];
                  meas_torque_ff <= res_ff[2];
                  turns_ff       <= total_next;
               end
               ACT_COMMAND: begin
                  tx_payload_ff <= {res_ff[0][15:0], res_ff[1][11:0], res_ff[2][11:0],
                                    res_ff[3][11:0], res_ff[4][11:0]};
                  last_ff       <= ~enter_send_ff;
               end
               default: tx_payload_ff <= {ADMIN_HEAD, tail_ff};
            endcase
         end
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.kind        = kind_ff;
   assign rsp_chan.tx_id       = tx_id_ff;
   assign rsp_chan.tx_payload  = tx_payload_ff;
   assign rsp_chan.meas_angle  = meas_angle_ff;
   assign rsp_chan.meas_speed  = meas_speed_ff;
   assign rsp_chan.meas_torque = meas_torque_ff;
   assign rsp_chan.turns_angle = turns_ff;
   assign rsp_chan.last        = last_ff;

endmodule
`default_nettype wire

// ----- verif/mit_motor_can_codec_unit_tb.sv -----
// Self-checking testbench of the motor CAN codec: random and directed words against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module mit_motor_can_codec_unit_tb import mmcc_pkg::*; ();

   // One input word as offered on the request channel.
   typedef struct {
      logic [1:0]         action;
      logic [10:0]        rx_frame_id;
      logic [63:0]        rx_payload;
      logic signed [31:0] want_angle;
      logic signed [31:0] want_speed;
      logic signed [31:0] want_torque;
      logic signed [31:0] stiffness;
      logic signed [31:0] damping;
      logic [1:0]         admin_kind;
   } motor_word_type;

   // One result word as seen on the result channel.
   typedef struct {
      logic               kind;
      logic [10:0]        tx_id;
      logic [63:0]        tx_payload;
      logic signed [31:0] meas_angle;
      logic signed [31:0] meas_speed;
      logic signed [31:0] meas_torque;
      logic signed [47:0] turns_angle;
      logic               last;
   } codec_result_type;

   localparam longint TURNS_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint TURNS_MIN = -TURNS_MAX - 1;
   localparam longint LIM_MAX   = 64'h7FFF_FFFF;

   logic clock;
   logic reset;
   mmcc_req_if req_if ();
   mmcc_rsp_if rsp_if ();
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   mit_motor_can_codec_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predictor copy of the registers and the tracked state.
   longint feedback_id_q, command_id_q, enter_send_q;
   longint angle_lim_q, speed_lim_q, torque_lim_q, stiff_lim_q, damp_lim_q;
   bit     seeded_q;
   longint prev_angle_q, total_angle_q, hold_angle_q, hold_speed_q, hold_torque_q;

   motor_word_type   pending_words[$];
   codec_result_type expected_results[$];
   motor_word_type   cur_word;
   bit               word_taken;
   int               send_idle_pct;
   int               recv_stall_pct;
   bit               hold_off;
   int               error_count;

   // Clock.
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic longint clip(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   function automatic longint decode_range(longint u, longint lim, longint full);
      if (lim == 0) begin
         return 0;
      end
      return -lim + (u * 2 * lim) / full;
   endfunction

   function automatic longint encode_range(longint x, longint lim, longint full);
      longint q;
      if (lim == 0) begin
         return 0;
      end
      q = ((clip(x, -lim, lim) + lim) * full) / (2 * lim);
      return q > full ? full : q;
   endfunction

   function automatic longint encode_gain(longint g, longint lim, longint full);
      longint q;
      if (lim == 0) begin
         return 0;
      end
      q = (clip(g, 0, lim) * full) / lim;
      return q > full ? full : q;
   endfunction

   function automatic codec_result_type frame_result(logic [63:0] payload);
      codec_result_type r;
      r = '{default: '0};
      r.kind = KIND_FRAME;
      r.tx_id = command_id_q[10:0];
      r.tx_payload = payload;
      return r;
   endfunction

   // Work out the results of one accepted word and update the state.
   task automatic predict_codec(motor_word_type w);
      codec_result_type r;
      longint a, s, t, d;
      logic [63:0] pl;
      case (w.action)
         ACT_FEEDBACK: begin
            if (w.rx_frame_id == feedback_id_q[10:0]) begin
               a = decode_range(w.rx_payload[55:40], angle_lim_q, 65535);
               s = decode_range(w.rx_payload[39:28], speed_lim_q, 4095);
               t = decode_range(w.rx_payload[27:16], torque_lim_q, 4095);
               if (!seeded_q) begin
                  seeded_q = 1;
                  total_angle_q = a;
               end else begin
                  d = a - prev_angle_q;
                  if (d > angle_lim_q) d -= 2 * angle_lim_q;
                  else if (d < -angle_lim_q) d += 2 * angle_lim_q;
                  total_angle_q = clip(total_angle_q + d, TURNS_MIN, TURNS_MAX);
               end
               prev_angle_q = a;
               r = '{default: '0};
               r.kind = KIND_FEEDBACK;
               r.meas_angle = a[31:0];
               r.meas_speed = s[31:0];
               r.meas_torque = t[31:0];
               r.turns_angle = total_angle_q[47:0];
               r.last = 1'b1;
               expected_results.push_back(r);
            end
         end
         ACT_TARGETS: begin
            hold_angle_q = clip(longint'(w.want_angle), -angle_lim_q, angle_lim_q);
            hold_speed_q = clip(longint'(w.want_speed), -speed_lim_q, speed_lim_q);
            hold_torque_q = clip(longint'(w.want_torque), -torque_lim_q, torque_lim_q);
         end
         ACT_COMMAND: begin
            pl = 64'(encode_range(hold_angle_q, angle_lim_q, 65535)) << 48;
            pl |= 64'(encode_range(hold_speed_q, speed_lim_q, 4095)) << 36;
            pl |= 64'(encode_gain(longint'(w.stiffness), stiff_lim_q, 4095)) << 24;
            pl |= 64'(encode_gain(longint'(w.damping), damp_lim_q, 4095)) << 12;
            pl |= 64'(encode_range(hold_torque_q, torque_lim_q, 4095));
            r = frame_result(pl);
            r.last = (enter_send_q == 0);
            expected_results.push_back(r);
            if (enter_send_q != 0) begin
               r = frame_result({ADMIN_HEAD, TAIL_ENTER});
               r.last = 1'b1;
               expected_results.push_back(r);
            end
         end
         default: begin
            if (w.admin_kind != ADMIN_BAD) begin
               r = frame_result({ADMIN_HEAD, TAIL_ENTER + 8'(w.admin_kind)});
               r.last = 1'b1;
               expected_results.push_back(r);
            end
         end
      endcase
   endtask

   // Request driver: note acceptance at the rising edge, drive at the falling edge.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         word_taken = 1;
         predict_codec(cur_word);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || word_taken) begin
         word_taken = 0;
         if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_word = pending_words.pop_front();
            req_if.action      <= cur_word.action;
            req_if.rx_frame_id <= cur_word.rx_frame_id;
            req_if.rx_payload  <= cur_word.rx_payload;
            req_if.want_angle  <= cur_word.want_angle;
            req_if.want_speed  <= cur_word.want_speed;
            req_if.want_torque <= cur_word.want_torque;
            req_if.stiffness   <= cur_word.stiffness;
            req_if.damping     <= cur_word.damping;
            req_if.admin_kind  <= cur_word.admin_kind;
            req_if.valid       <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result monitor: compare each accepted word with the oldest expectation.
   always @(posedge clock) begin
      codec_result_type exp_r;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result word kind=%0d payload=%h", $time,
                     rsp_if.kind, rsp_if.tx_payload);
            error_count++;
         end else begin
            exp_r = expected_results.pop_front();
            if (exp_r.kind !== rsp_if.kind || exp_r.tx_id !== rsp_if.tx_id ||
                exp_r.tx_payload !== rsp_if.tx_payload ||
                exp_r.meas_angle !== rsp_if.meas_angle ||
                exp_r.meas_speed !== rsp_if.meas_speed ||
                exp_r.meas_torque !== rsp_if.meas_torque ||
                exp_r.turns_angle !== rsp_if.turns_angle || exp_r.last !== rsp_if.last) begin
               $display({"%0t: mismatch expected kind=%0d id=%h pl=%h ang=%0d spd=%0d",
                         " trq=%0d turns=%0d last=%0d"},
                        $time, exp_r.kind, exp_r.tx_id, exp_r.tx_payload, exp_r.meas_angle,
                        exp_r.meas_speed, exp_r.meas_torque, exp_r.turns_angle, exp_r.last);
               $display({"%0t:          actual   kind=%0d id=%h pl=%h ang=%0d spd=%0d",
                         " trq=%0d turns=%0d last=%0d"},
                        $time, rsp_if.kind, rsp_if.tx_id, rsp_if.tx_payload, rsp_if.meas_angle,
                        rsp_if.meas_speed, rsp_if.meas_torque, rsp_if.turns_angle, rsp_if.last);
               error_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= !reset && !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // Long receiver hold-off, so the block backs up and stalls its input.
   initial begin
      wait (hold_off);
      repeat (3000) @(posedge clock);
      hold_off = 0;
   end

   // Register write over the configuration port; also updates the predictor.
   task automatic write_reg(logic [2:0] idx, longint value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value[31:0];
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_FEEDBACK_ID: feedback_id_q = value & 11'h7FF;
         REG_COMMAND_ID:  command_id_q = value & 11'h7FF;
         REG_ANGLE_LIM:   angle_lim_q = value & LIM_MAX;
         REG_SPEED_LIM:   speed_lim_q = value & LIM_MAX;
         REG_TORQUE_LIM:  torque_lim_q = value & LIM_MAX;
         REG_STIFF_LIM:   stiff_lim_q = value & LIM_MAX;
         REG_DAMP_LIM:    damp_lim_q = value & LIM_MAX;
         default:         enter_send_q = value & 1;
      endcase
   endtask

   function automatic longint pick_limit();
      case ($urandom_range(4))
         0: return 1;
         1: return LIM_MAX;
         2: return $urandom_range(1, 1 << 20);
         default: return $urandom_range(1, 32'h7FFF_FFFF);
      endcase
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(5))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 32'(signed'($urandom_range(0, 1 << 22)) - (1 << 21));
         default: return $urandom;
      endcase
   endfunction

   function automatic motor_word_type make_word(logic [1:0] action);
      motor_word_type w;
      w.action = action;
      w.rx_frame_id = ($urandom_range(9) == 0) ? 11'($urandom) : feedback_id_q[10:0];
      w.rx_payload = {$urandom, $urandom};
      w.want_angle = pick_value();
      w.want_speed = pick_value();
      w.want_torque = pick_value();
      w.stiffness = pick_value();
      w.damping = pick_value();
      w.admin_kind = 2'($urandom_range(3));
      return w;
   endfunction

   task automatic push_word(logic [1:0] action, logic [63:0] payload,
                            logic signed [31:0] v0, logic signed [31:0] v1,
                            logic [1:0] kind);
      motor_word_type w;
      w = make_word(action);
      w.rx_frame_id = feedback_id_q[10:0];
      w.rx_payload = payload;
      w.want_angle = v0;
      w.want_speed = v1;
      w.want_torque = v0;
      w.stiffness = v0;
      w.damping = v1;
      w.admin_kind = kind;
      pending_words.push_back(w);
   endtask

   // Wait until all words are taken and all results are in, then let the block settle.
   task automatic drain();
      while (pending_words.size() > 0 || req_if.valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic random_phase(int count, int idle_pct, int stall_pct);
      int r;
      logic [1:0] act;
      for (int i = 0; i < 8; i++) begin
         case (i)
            0, 1: write_reg(3'(i), $urandom_range(2047));
            7: write_reg(3'(i), $urandom_range(1));
            default: write_reg(3'(i), pick_limit());
         endcase
      end
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         act = r < 40 ? ACT_FEEDBACK : r < 60 ? ACT_TARGETS : r < 85 ? ACT_COMMAND : ACT_ADMIN;
         pending_words.push_back(make_word(act));
      end
      drain();
   endtask

   // Main sequence.
   initial begin
      motor_word_type w;
      error_count = 0;
      hold_off = 0;
      word_taken = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_if.valid = 1'b0;
      req_if.action = ACT_TARGETS;
      req_if.rx_frame_id = '0;
      req_if.rx_payload = '0;
      req_if.want_angle = '0;
      req_if.want_speed = '0;
      req_if.want_torque = '0;
      req_if.stiffness = '0;
      req_if.damping = '0;
      req_if.admin_kind = ADMIN_ENTER;
      rsp_if.ready = 1'b0;
      feedback_id_q = RST_FEEDBACK_ID;
      command_id_q = RST_COMMAND_ID;
      angle_lim_q = RST_ANGLE_LIM;
      speed_lim_q = RST_SPEED_LIM;
      torque_lim_q = RST_TORQUE_LIM;
      stiff_lim_q = RST_STIFF_LIM;
      damp_lim_q = RST_DAMP_LIM;
      enter_send_q = 0;
      seeded_q = 0;
      prev_angle_q = 0;
      total_angle_q = 0;
      hold_angle_q = 0;
      hold_speed_q = 0;
      hold_torque_q = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed words at reset settings: a foreign id, first frame seeds, extremes, wrap, all actions.
      w = make_word(ACT_FEEDBACK);
      w.rx_frame_id = 11'h7FF;
      pending_words.push_back(w);
      push_word(ACT_FEEDBACK, 64'h0, 0, 0, ADMIN_ENTER);
      push_word(ACT_FEEDBACK, '1, 0, 0, ADMIN_ENTER);
      push_word(ACT_FEEDBACK, 64'h0000_0000_0000_0000, 0, 0, ADMIN_ENTER);
      push_word(ACT_FEEDBACK, 64'h00FF_FF7F_F800_0000, 0, 0, ADMIN_ENTER);
      push_word(ACT_COMMAND, '0, 0, 0, ADMIN_ENTER);
      push_word(ACT_TARGETS, '0, 32'sh7FFF_FFFF, 32'sh8000_0000, ADMIN_ENTER);
      push_word(ACT_COMMAND, '0, 32'sh7FFF_FFFF, 32'sh8000_0000, ADMIN_ENTER);
      push_word(ACT_TARGETS, '0, 32'sh8000_0000, 32'sh7FFF_FFFF, ADMIN_ENTER);
      push_word(ACT_COMMAND, '0, 32'sh0001_0000, 32'sh0000_8000, ADMIN_ENTER);
      for (int k = 0; k < 4; k++) push_word(ACT_ADMIN, '0, 0, 0, 2'(k));
      drain();

      // Enter frame after each command, then new limits, the angle and torque limits cut below the stored targets.
      write_reg(REG_ENTER_SEND, 1);
      write_reg(REG_COMMAND_ID, 2047);
      push_word(ACT_TARGETS, '0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, ADMIN_ENTER);
      push_word(ACT_COMMAND, '0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, ADMIN_ENTER);
      drain();
      write_reg(REG_ANGLE_LIM, 1);
      write_reg(REG_SPEED_LIM, LIM_MAX);
      write_reg(REG_TORQUE_LIM, 1000);
      write_reg(REG_STIFF_LIM, 1);
      write_reg(REG_DAMP_LIM, LIM_MAX);
      push_word(ACT_COMMAND, '0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, ADMIN_ENTER);
      drain();

      // A limit of zero encodes and decodes as zero.
      write_reg(REG_ANGLE_LIM, 0);
      write_reg(REG_SPEED_LIM, 0);
      write_reg(REG_FEEDBACK_ID, 2047);
      write_reg(REG_ENTER_SEND, 0);
      push_word(ACT_FEEDBACK, '1, 0, 0, ADMIN_ENTER);
      push_word(ACT_COMMAND, '0, 32'sh0000_1000, 32'sh0000_1000, ADMIN_ENTER);
      drain();

      // Random phases under several settings and idling patterns.
      random_phase(150, 0, 0);
      random_phase(150, 56, 0);
      random_phase(150, 0, 56);
      random_phase(150, 7, 7);
      hold_off = 1;
      random_phase(100, 0, 0);
      random_phase(100, 20, 20);

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire
